// ===== sv/olt_pkg.sv =====
// ----------------------------------------------------------------------------
// olt_pkg: shared types and constants of the ordered list table
// Request and result structs, operation and status codes, and the control
// word that is broadcast to every storage cell.
// ----------------------------------------------------------------------------
package olt_pkg;

    localparam int DEPTH     = 16;
    localparam int WORD_BITS = 32;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = 5;

    typedef enum logic [2:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_INSERT = 3'd2,
        OP_REMOVE = 3'd3,
        OP_GET    = 3'd4,
        OP_SET    = 3'd5,
        OP_CLEAR  = 3'd6,
        OP_FIND   = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef struct packed {
        t_op         op;
        logic [4:0]  index;
        logic [31:0] item;
    } t_req;

    typedef struct packed {
        logic [31:0] item_out;
        logic [3:0]  position;
        logic [4:0]  count;
        t_status     status;
    } t_rsp;

    // What every cell does this cycle, relative to the broadcast index.
    typedef enum logic [1:0] {
        C_HOLD  = 2'd0,   // keep contents
        C_WRITE = 2'd1,   // cell at idx takes the word
        C_OPEN  = 2'd2,   // cells above idx take from below, idx takes word
        C_CLOSE = 2'd3    // cells at and above idx take from above
    } t_cell_mode;

    typedef struct packed {
        t_cell_mode           mode;
        logic [CNT_W-1:0]     idx;
        logic [WORD_BITS-1:0] word;
    } t_cell_ctl;

endpackage

// ===== sv/olt_cell.sv =====
// ----------------------------------------------------------------------------
// olt_cell: one storage cell of the ordered list table
// Holds one word, shifts from either neighbor or loads the broadcast word,
// and flags whether its contents equal the broadcast key.
// ----------------------------------------------------------------------------
module olt_cell
    import olt_pkg::*;
(
    input  logic                 i_clk,
    input  t_cell_ctl            i_ctl,
    input  logic [IDX_W-1:0]     i_pos,
    input  logic [WORD_BITS-1:0] i_prev,
    input  logic [WORD_BITS-1:0] i_next,
    output logic [WORD_BITS-1:0] o_data,
    output logic                 o_match
);

    logic [WORD_BITS-1:0] r_data;
    logic [WORD_BITS-1:0] n_data;
    logic [CNT_W-1:0]     w_pos;

    assign w_pos = CNT_W'(i_pos);

    always_comb begin
        n_data = r_data;
        case (i_ctl.mode)
            C_WRITE: begin
                if (w_pos == i_ctl.idx) n_data = i_ctl.word;
            end
            C_OPEN: begin
                if (w_pos == i_ctl.idx)     n_data = i_ctl.word;
                else if (w_pos > i_ctl.idx) n_data = i_prev;
            end
            C_CLOSE: begin
                if (w_pos >= i_ctl.idx) n_data = i_next;
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_match = (r_data == i_ctl.word);

endmodule

// ===== sv/ordered_list_table.sv =====
// ----------------------------------------------------------------------------
// ordered_list_table: fixed-capacity ordered list of data words
// A row of cells holds the list; requests push, pop, insert, remove, get,
// set, clear or search it, each returning one result.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive i_req and raise start; the request is taken at a
//   rising edge where start is high and busy is low. busy is high for the
//   one cycle the taken request is being executed.
//   Result channel: o_valid pulses for exactly one cycle with o_rsp; the
//   receiver must take it then, it cannot stall the block.
// Timing:
//   The request is registered at the accepting edge; in the next cycle all
//   cells shift or load in parallel while the read mux and the first-match
//   encoder form the result register. No new request is taken while busy.
// Reset:
//   Synchronous, active low. Clears the count, the pending flag and o_valid.
//   Cell contents are not cleared; entries at or above the count are never
//   reported.
// Status: ST_OK, ST_MISS (empty, index out of range, no match), ST_FULL.
// ----------------------------------------------------------------------------
module ordered_list_table
    import olt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_valid,
    output t_rsp o_rsp
);

    t_req                 r_req;
    logic                 r_pend;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic                 r_valid;
    t_rsp                 r_rsp;
    t_rsp                 n_rsp;
    t_cell_ctl            w_ctl;

    logic [WORD_BITS-1:0] w_data  [DEPTH];
    logic [DEPTH-1:0]     w_match;

    logic                 w_full;
    logic                 w_idx_ok;
    logic [IDX_W-1:0]     w_top;
    logic                 w_found;
    logic [IDX_W-1:0]     w_fpos;

    // Row of cells; cell g takes from g-1 on insert and from g+1 on remove.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WORD_BITS-1:0] w_prev;
        logic [WORD_BITS-1:0] w_next;
        if (g == 0) begin : g_first
            assign w_prev = w_ctl.word;
        end else begin : g_mid_lo
            assign w_prev = w_data[g-1];
        end
        if (g == DEPTH-1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid_hi
            assign w_next = w_data[g+1];
        end
        olt_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_pos   (IDX_W'(g)),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .o_data  (w_data[g]),
            .o_match (w_match[g])
        );
    end

    assign w_full   = (r_count == CNT_W'(DEPTH));
    assign w_idx_ok = (CNT_W'(r_req.index) < r_count);
    assign w_top    = IDX_W'(r_count - CNT_W'(1));

    // First match among the live entries; lowest index wins.
    always_comb begin
        w_found = 1'b0;
        w_fpos  = '0;
        for (int i = DEPTH-1; i >= 0; i--) begin
            if (w_match[i] && (CNT_W'(i) < r_count)) begin
                w_found = 1'b1;
                w_fpos  = IDX_W'(i);
            end
        end
    end

    // Decode the pending request into a cell command and the result.
    always_comb begin
        w_ctl.mode     = C_HOLD;
        w_ctl.idx      = CNT_W'(r_req.index);
        w_ctl.word     = WORD_BITS'(r_req.item);
        n_count        = r_count;
        n_rsp.item_out = '0;
        n_rsp.position = '0;
        n_rsp.status   = ST_OK;
        if (r_pend) begin
            case (r_req.op)
                OP_PUSH: begin
                    if (w_full) begin
                        n_rsp.status = ST_FULL;
                    end else begin
                        w_ctl.mode = C_WRITE;
                        w_ctl.idx  = r_count;
                        n_count    = r_count + CNT_W'(1);
                    end
                end
                OP_POP: begin
                    if (r_count == '0) begin
                        n_rsp.status = ST_MISS;
                    end else begin
                        n_rsp.item_out = 32'(w_data[w_top]);
                        n_count        = r_count - CNT_W'(1);
                    end
                end
                OP_INSERT: begin
                    if (CNT_W'(r_req.index) > r_count) begin
                        n_rsp.status = ST_MISS;
                    end else if (w_full) begin
                        n_rsp.status = ST_FULL;
                    end else begin
                        w_ctl.mode = C_OPEN;
                        n_count    = r_count + CNT_W'(1);
                    end
                end
                OP_REMOVE: begin
                    if (!w_idx_ok) begin
                        n_rsp.status = ST_MISS;
                    end else begin
                        w_ctl.mode     = C_CLOSE;
                        n_rsp.item_out = 32'(w_data[r_req.index[IDX_W-1:0]]);
                        n_count        = r_count - CNT_W'(1);
                    end
                end
                OP_GET: begin
                    if (!w_idx_ok) n_rsp.status = ST_MISS;
                    else n_rsp.item_out = 32'(w_data[r_req.index[IDX_W-1:0]]);
                end
                OP_SET: begin
                    if (!w_idx_ok) n_rsp.status = ST_MISS;
                    else w_ctl.mode = C_WRITE;
                end
                OP_CLEAR: begin
                    n_count = '0;
                end
                OP_FIND: begin
                    if (w_found) n_rsp.position = 4'(w_fpos);
                    else n_rsp.status = ST_MISS;
                end
                default: n_rsp.status = ST_MISS;
            endcase
        end
        n_rsp.count = 5'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_pend  <= start && !r_pend;
            r_count <= n_count;
            r_valid <= r_pend;
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge i_clk) begin
        if (start && !r_pend) r_req <= i_req;
        if (r_pend) r_rsp <= n_rsp;
    end

    assign busy    = r_pend;
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule
